// ===== src/swms_pkg.sv =====
// Shared types and constants for the mid/side stereo width block.
// Used by swms_ctrl, swms_dp and stereo_width_mid_side_top; no dependencies.
package swms_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 8;

  localparam int WIDTH_FRAC  = 13;
  localparam int GAIN_FRAC   = 12;
  localparam int COEFF_FRAC  = 16;

  localparam logic [CFG_W-1:0] WIDTH_FLOOR   = 16'd410;
  localparam logic [CFG_W-1:0] WIDTH_RESET   = 16'd8192;
  localparam logic [CFG_W-1:0] GAIN_RESET    = 16'd4096;
  localparam logic [CFG_W-1:0] COEFF_RESET   = 16'd0;

  // multiplier operand and product widths
  localparam int OP_W   = SAMPLE_BITS + 6;
  localparam int MB_W   = CFG_W + 1;
  localparam int PROD_W = OP_W + MB_W;

  localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] REG_WIDEN_ENABLE = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_GAIN   = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPLIT_COEFF  = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MATCH_GAIN   = 8'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOW,
    ST_SCALE,
    ST_LEFT,
    ST_RIGHT,
    ST_MONO
  } swms_state_t;

  typedef enum logic [1:0] {
    MUL_LOW,
    MUL_SCALE,
    MUL_LEFT,
    MUL_RIGHT
  } swms_op_t;

  typedef struct packed {
    logic     load_in;
    logic     step_en;
    swms_op_t op;
    logic     load_out;
    logic     mono;
  } swms_cmd_t;

  typedef struct packed {
    logic widen;
    logic split_on;
  } swms_stat_t;

endpackage

// ===== src/swms_ctrl.sv =====
// Sequencer for the mid/side width block: request handshakes and multiplier steps.
// Depends on swms_pkg; drives swms_dp through swms_cmd_t.
module swms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  swms_pkg::swms_stat_t stat,
  output swms_pkg::swms_cmd_t  cmd
);
  import swms_pkg::*;

  swms_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = MUL_LOW;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          if (!stat.widen) begin
            state_nxt = ST_MONO;
          end else if (stat.split_on) begin
            state_nxt = ST_LOW;
          end else begin
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_LOW: begin
        cmd.step_en = 1'b1;
        cmd.op      = MUL_LOW;
        state_nxt   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.step_en = 1'b1;
        cmd.op      = MUL_SCALE;
        state_nxt   = ST_LEFT;
      end
      ST_LEFT: begin
        cmd.step_en = 1'b1;
        cmd.op      = MUL_LEFT;
        state_nxt   = ST_RIGHT;
      end
      ST_RIGHT: begin
        cmd.op = MUL_RIGHT;
        if (out_free) begin
          cmd.step_en  = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_MONO: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.mono     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/swms_dp.sv =====
// Datapath for the mid/side width block: registers, low tracker, shared multiplier.
// Depends on swms_pkg; steered by swms_ctrl through swms_cmd_t.
module swms_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [swms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [swms_pkg::CFG_W-1:0]      cfg_data,
  input  swms_pkg::sample_t               left_sample,
  input  swms_pkg::sample_t               right_sample,
  input  swms_pkg::swms_cmd_t             cmd,
  output swms_pkg::swms_stat_t            stat,
  output swms_pkg::sample_t               out_left,
  output swms_pkg::sample_t               out_right,
  output swms_pkg::sample_t               out_mid
);
  import swms_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [PROD_W:0] HALF_COEFF = (PROD_W+1)'(1) <<< (COEFF_FRAC - 1);
  localparam logic signed [PROD_W:0] HALF_WIDTH = (PROD_W+1)'(1) <<< (WIDTH_FRAC - 1);
  localparam logic signed [PROD_W:0] HALF_GAIN  = (PROD_W+1)'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [PROD_W:0] SAT_HI = {{(PROD_W-SB+2){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PROD_W:0] SAT_LO = {{(PROD_W-SB+2){1'b1}}, {(SB-1){1'b0}}};

  logic             widen_r;
  logic [CFG_W-1:0] width_r, coeff_r, gain_r;

  sample_t mid_r, side_r, low_r, left_r;
  sample_t out_left_r, out_right_r, out_mid_r;
  logic signed [OP_W-1:0] scaled_r;

  logic signed [SB:0]     sum_in, diff_in;
  logic [CFG_W-1:0]       width_eff;
  logic signed [OP_W-1:0] op_a;
  logic signed [MB_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0] prod_x, rnd_coeff, rnd_width, rnd_gain;
  sample_t                sat_val;

  assign sum_in    = (SB+1)'(left_sample) + (SB+1)'(right_sample);
  assign diff_in   = (SB+1)'(left_sample) - (SB+1)'(right_sample);
  assign width_eff = (width_r < WIDTH_FLOOR) ? WIDTH_FLOOR : width_r;

  assign stat.widen    = widen_r;
  assign stat.split_on = (coeff_r != '0);

  always_comb begin
    case (cmd.op)
      MUL_LOW: begin
        op_a = OP_W'(side_r) - OP_W'(low_r);
        op_b = signed'({1'b0, coeff_r});
      end
      MUL_SCALE: begin
        op_a = stat.split_on ? (OP_W'(side_r) - OP_W'(low_r)) : OP_W'(side_r);
        op_b = signed'({1'b0, width_eff});
      end
      MUL_LEFT: begin
        op_a = OP_W'(mid_r) + scaled_r;
        op_b = signed'({1'b0, gain_r});
      end
      default: begin
        op_a = OP_W'(mid_r) - scaled_r;
        op_b = signed'({1'b0, gain_r});
      end
    endcase
  end

  assign prod      = op_a * op_b;
  assign prod_x    = (PROD_W+1)'(prod);
  assign rnd_coeff = (prod_x + HALF_COEFF) >>> COEFF_FRAC;
  assign rnd_width = (prod_x + HALF_WIDTH) >>> WIDTH_FRAC;
  assign rnd_gain  = (prod_x + HALF_GAIN) >>> GAIN_FRAC;

  always_comb begin
    if (rnd_gain > SAT_HI) begin
      sat_val = SAT_HI[SB-1:0];
    end else if (rnd_gain < SAT_LO) begin
      sat_val = SAT_LO[SB-1:0];
    end else begin
      sat_val = rnd_gain[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widen_r <= 1'b1;
      width_r <= WIDTH_RESET;
      coeff_r <= COEFF_RESET;
      gain_r  <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDEN_ENABLE: widen_r <= cfg_data[0];
        REG_WIDTH_GAIN:   width_r <= cfg_data;
        REG_SPLIT_COEFF:  coeff_r <= cfg_data;
        REG_MATCH_GAIN:   gain_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0;
    end else if (cfg_we && cfg_addr == REG_SPLIT_COEFF) begin
      low_r <= '0;
    end else if (cmd.step_en && cmd.op == MUL_LOW) begin
      low_r <= low_r + rnd_coeff[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mid_r  <= sum_in[SB:1];
      side_r <= diff_in[SB:1];
    end
    if (cmd.step_en && cmd.op == MUL_SCALE) begin
      scaled_r <= rnd_width[OP_W-1:0];
    end
    if (cmd.step_en && cmd.op == MUL_LEFT) begin
      left_r <= sat_val;
    end
    if (cmd.load_out) begin
      out_mid_r <= mid_r;
      if (cmd.mono) begin
        out_left_r  <= mid_r;
        out_right_r <= mid_r;
      end else begin
        out_left_r  <= left_r;
        out_right_r <= sat_val;
      end
    end
  end

  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_mid   = out_mid_r;

endmodule

// ===== src/stereo_width_mid_side_top.sv =====
// Mid/side stereo widener with bass-mono split, top level.
// A new pair is accepted only when idle, after the previous result has been loaded for output;
// one shared multiplier takes up to four products per pair. Synchronous active-low reset
// restores register defaults (enable 1, width 1.0, no split, gain 1.0) and clears the low
// tracker; a split write also clears it.
// Depends on swms_pkg, swms_ctrl and swms_dp.
module stereo_width_mid_side_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [swms_pkg::IN_DATA_W-1:0]   in_tdata,   // left_sample, right_sample
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [swms_pkg::OUT_DATA_W-1:0]  out_tdata,  // out_left, out_right, out_mid
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [swms_pkg::CFG_W-1:0]       cfg_data
);
  import swms_pkg::*;

  swms_cmd_t  cmd;
  swms_stat_t stat;
  sample_t    left_sample, right_sample;
  sample_t    out_left, out_right, out_mid;

  assign cfg_ready    = 1'b1;
  assign left_sample  = in_tdata[SAMPLE_BITS-1:0];
  assign right_sample = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign out_tdata    = OUT_DATA_W'({out_mid, out_right, out_left});

  swms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  swms_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .cmd          (cmd),
    .stat         (stat),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_mid      (out_mid)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for stereo_width_mid_side_top: random and directed stereo requests,
// register phases and random idling on both sides, checked against an in-bench predictor.
// Depends on swms_pkg and the RTL of stereo_width_mid_side_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swms_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 8'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LAST  = 8'hFF;
  localparam sample_t S_MAX = 24'h7FFFFF;
  localparam sample_t S_MIN = 24'h800000;

  typedef struct {
    sample_t left;
    sample_t right;
  } pair_t;

  typedef struct {
    sample_t left;
    sample_t right;
    sample_t mid;
  } outs_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]       cfg_data;

  pair_t pair_q[$];
  outs_t outs_due[$];
  int    issued;
  int    accepted_n;
  int    fails;
  int    idle_run;
  int    send_pct;
  int    recv_pct;
  logic  in_took;
  logic  cfg_took;

  logic         widen_on;
  logic [15:0]  width_reg;
  logic [15:0]  coeff_reg;
  logic [15:0]  gain_reg;
  longint       side_lp;

  outs_t got;

  stereo_width_mid_side_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint round_half_up(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic sample_t clamp_sample(input longint x);
    if (x > longint'(S_MAX)) return S_MAX;
    if (x < longint'(S_MIN)) return S_MIN;
    return sample_t'(x);
  endfunction

  // predicts the outputs for one pair; advances the low tracker when widening with the split active
  function automatic outs_t widen_pair(input sample_t l, input sample_t r);
    longint lv, rv, mid, side, w, c, g, scaled;
    outs_t  res;
    lv = longint'(l);
    rv = longint'(r);
    mid = (lv + rv) >>> 1;
    side = (lv - rv) >>> 1;
    res.mid = sample_t'(mid);
    if (!widen_on) begin
      res.left = sample_t'(mid);
      res.right = sample_t'(mid);
      return res;
    end
    w = longint'((width_reg < WIDTH_FLOOR) ? WIDTH_FLOOR : width_reg);
    c = longint'(coeff_reg);
    g = longint'(gain_reg);
    if (c != 0) begin
      side_lp = side_lp + round_half_up((side - side_lp) * c, COEFF_FRAC);
      scaled = round_half_up((side - side_lp) * w, WIDTH_FRAC);
    end else begin
      scaled = round_half_up(side * w, WIDTH_FRAC);
    end
    res.left = clamp_sample(round_half_up((mid + scaled) * g, GAIN_FRAC));
    res.right = clamp_sample(round_half_up((mid - scaled) * g, GAIN_FRAC));
    return res;
  endfunction

  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_WIDEN_ENABLE: widen_on = val[0];
      REG_WIDTH_GAIN:   width_reg = val;
      REG_SPLIT_COEFF: begin
        coeff_reg = val;
        side_lp = 0;
      end
      REG_MATCH_GAIN:   gain_reg = val;
      default: ;
    endcase
  endfunction

  task automatic compare_field(input string name, input sample_t want, input sample_t have);
    if (have !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, have);
      fails++;
    end
  endtask

  // driver: hold a request until taken, then advance or idle
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_took) begin
        if (pair_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          in_tdata <= {pair_q[0].right, pair_q[0].left};
          in_tvalid <= 1'b1;
          void'(pair_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // monitor: track register writes, predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      cfg_took <= 1'b0;
      idle_run <= 0;
      widen_on = 1'b1;
      width_reg = WIDTH_RESET;
      coeff_reg = COEFF_RESET;
      gain_reg = GAIN_RESET;
      side_lp = 0;
    end else begin
      in_took <= in_tvalid && in_tready;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) apply_reg(cfg_addr, cfg_data);
      if (in_tvalid && in_tready) begin
        outs_due.insert(outs_due.size(),
                        widen_pair(in_tdata[SAMPLE_BITS-1:0],
                                   in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
        accepted_n <= accepted_n + 1;
      end
      if (out_tvalid && out_tready) begin
        got.left = out_tdata[SAMPLE_BITS-1:0];
        got.right = out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        got.mid = out_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
        if (outs_due.size() == 0) begin
          $display("%0t: unexpected result expected none got %h", $time, out_tdata);
          fails++;
        end else begin
          compare_field("out_left", outs_due[0].left, got.left);
          compare_field("out_right", outs_due[0].right, got.right);
          compare_field("out_mid", outs_due[0].mid, got.mid);
          void'(outs_due.pop_front());
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_run <= 0;
      else
        idle_run <= idle_run + 1;
    end
  end

  initial begin
    while (idle_run < WATCHDOG_LIMIT) @(negedge clk);
    $display("stereo_width_mid_side_top regression: fail");
    $finish;
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pair(input sample_t l, input sample_t r);
    pair_t p;
    p.left = l;
    p.right = r;
    pair_q.insert(pair_q.size(), p);
    issued++;
  endtask

  task automatic settle();
    do @(negedge clk); while (accepted_n != issued || outs_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_random(input int n);
    sample_t l, r;
    int      kind;
    repeat (n) begin
      kind = $urandom_range(0, 6);
      l = sample_t'($urandom);
      r = sample_t'($urandom);
      case (kind)
        2: r = ~l;
        3: r = l + sample_t'(int'($urandom_range(0, 4095)) - 2048);
        4: begin
          l = $urandom_range(1) ? S_MAX : S_MIN;
          r = $urandom_range(1) ? S_MAX : S_MIN;
        end
        5: begin
          l = sample_t'(int'($urandom_range(0, 511)) - 256);
          r = sample_t'(int'($urandom_range(0, 511)) - 256);
        end
        default: ;
      endcase
      queue_pair(l, r);
    end
  endtask

  task automatic queue_extremes();
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);
    queue_pair(S_MAX, S_MIN);
    queue_pair(S_MIN, S_MAX);
  endtask

  task automatic random_settings();
    logic [CFG_W-1:0] w, c, g;
    case ($urandom_range(0, 3))
      0: w = 16'($urandom_range(0, 409));
      1: w = 16'($urandom_range(410, 16384));
      default: w = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: c = 16'd0;
      1: c = 16'($urandom_range(60000, 65535));
      default: c = 16'($urandom_range(1, 65535));
    endcase
    g = $urandom_range(0, 1) ? 16'($urandom_range(0, 8192)) : 16'($urandom);
    write_reg(REG_WIDEN_ENABLE, ($urandom_range(0, 4) != 0) ? 16'($urandom) | 16'd1 : 16'd0);
    write_reg(REG_WIDTH_GAIN, w);
    write_reg(REG_SPLIT_COEFF, c);
    write_reg(REG_MATCH_GAIN, g);
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_SPARE + 8'($urandom_range(0, 250)), 16'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    issued = 0;
    accepted_n = 0;
    fails = 0;
    idle_run = 0;
    send_pct = 35;
    recv_pct = 55;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: full width, no split, unity gain
    queue_extremes();
    queue_pair(24'sd0, 24'sd0);
    queue_pair(-24'sd1, -24'sd1);
    queue_pair(24'sd1, -24'sd1);
    queue_pair(-24'sd1, 24'sd0);
    queue_pair(24'sd0, S_MIN);
    queue_pair(24'h555555, 24'hAAAAAA);
    queue_pair(24'hAAAAAA, 24'h555555);
    settle();

    // mono through the enable bit with excess bits set
    write_reg(REG_WIDEN_ENABLE, 16'hFFFE);
    queue_extremes();
    queue_pair(-24'sd1, 24'sd0);
    queue_random(20);
    settle();

    // width below floor, largest gain: saturate
    write_reg(REG_WIDEN_ENABLE, 16'd1);
    write_reg(REG_WIDTH_GAIN, 16'd0);
    write_reg(REG_MATCH_GAIN, 16'hFFFF);
    queue_extremes();
    queue_pair(24'sd3, -24'sd3);
    queue_random(30);
    settle();

    // widest, strongest split
    write_reg(REG_WIDTH_GAIN, 16'hFFFF);
    write_reg(REG_SPLIT_COEFF, 16'hFFFF);
    queue_extremes();
    queue_random(40);
    settle();

    // just under the floor, weakest split, zero gain, writes to absent registers
    write_reg(REG_WIDTH_GAIN, 16'd409);
    write_reg(REG_SPLIT_COEFF, 16'd1);
    write_reg(REG_MATCH_GAIN, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_LAST, 16'h0000);
    queue_random(30);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_pct = 55;
        recv_pct = 35;
      end else if (ph == 8) begin
        send_pct = 0;
        recv_pct = 0;
      end
      random_settings();
      queue_random(22);
      if (ph == 1) settle();
      queue_random(23);
      settle();
    end

    if (fails == 0) begin
      $display("stereo_width_mid_side_top regression: pass");
    end else begin
      $display("stereo_width_mid_side_top regression: fail");
    end
    $finish;
  end

endmodule
